// ===== rtl/sfq_pkg.sv =====
// Shared types and constants for the searchable FIFO queue.
package sfq_pkg;

  // Queue depth; the circular addressing needs a power of two.
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_ENQ    = 3'd0,
    CMD_DEQ    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_CLEAR  = 3'd4
  } sfq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } sfq_status_e;

  // Result updates that the controller asks the datapath to commit.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ENQ,
    RES_DEQ,
    RES_REMOVE,
    RES_FIND,
    RES_CLEAR,
    RES_MISS
  } sfq_res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQW,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } sfq_state_e;

  typedef struct packed {
    logic     load_item;
    logic     step;
    logic     shift_init;
    logic     shift_wr;
    sfq_res_e res_op;
    logic     load_out;
  } sfq_dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       cnt_zero;
    logic       hit;
    logic       pipe_done;
    logic       out_busy;
  } sfq_dp_sts_t;

endpackage

// ===== rtl/sfq_dp.sv =====
// Datapath: entry memory, head and count, scan/shift pipeline and result registers.
module sfq_dp import sfq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [2:0]             cmd_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  sfq_dp_cmd_t            dp_cmd_i,
  output sfq_dp_sts_t            dp_sts_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [1:0]             status_o,
  output logic [VALUE_WIDTH-1:0] out_value_o,
  output logic [CNT_W-1:0]       count_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [ADDR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   pipe_vld_q, pipe_vld_d;
  logic [ADDR_W-1:0]      pipe_idx_q, pipe_idx_d;
  logic [2:0]             cmd_q, cmd_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic [1:0]             res_status_q, res_status_d;
  logic [VALUE_WIDTH-1:0] res_value_q, res_value_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_status_q, out_status_d;
  logic [VALUE_WIDTH-1:0] out_value_q, out_value_d;
  logic [CNT_W-1:0]       out_count_q, out_count_d;

  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    pipe_vld_d   = pipe_vld_q;
    pipe_idx_d   = pipe_idx_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = head_q + rd_idx_q[ADDR_W-1:0];

    if (dp_cmd_i.load_item) begin
      cmd_d      = cmd_i;
      key_d      = value_i;
      rd_idx_d   = '0;
      pipe_vld_d = 1'b0;
    end

    // Issue one read per cycle; the compare or move happens in the cycle after the read.
    if (dp_cmd_i.step) begin
      if (rd_idx_q < count_q) begin
        mem_re     = 1'b1;
        pipe_vld_d = 1'b1;
        pipe_idx_d = rd_idx_q[ADDR_W-1:0];
        rd_idx_d   = rd_idx_q + CNT_W'(1);
      end else begin
        pipe_vld_d = 1'b0;
      end
    end

    // Compaction restarts the read side just past the matching slot.
    if (dp_cmd_i.shift_init) begin
      rd_idx_d   = {1'b0, pipe_idx_q} + CNT_W'(1);
      pipe_vld_d = 1'b0;
    end

    if (dp_cmd_i.shift_wr && pipe_vld_q) begin
      mem_we    = 1'b1;
      mem_waddr = head_q + pipe_idx_q - ADDR_W'(1);
      mem_wdata = rdata_q;
    end

    case (dp_cmd_i.res_op)
      RES_ENQ: begin
        res_value_d = '0;
        if (count_q == CNT_W'(DEPTH)) begin
          res_status_d = ST_FULL;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = head_q + count_q[ADDR_W-1:0];
          mem_wdata    = key_q;
          count_d      = count_q + CNT_W'(1);
          res_status_d = ST_OK;
        end
      end
      RES_DEQ: begin
        res_status_d = ST_OK;
        res_value_d  = rdata_q;
        head_d       = head_q + ADDR_W'(1);
        count_d      = count_q - CNT_W'(1);
      end
      RES_REMOVE: begin
        res_status_d = ST_OK;
        res_value_d  = '0;
        count_d      = count_q - CNT_W'(1);
      end
      RES_FIND: begin
        res_status_d = ST_OK;
        res_value_d  = rdata_q;
      end
      RES_CLEAR: begin
        res_status_d = ST_OK;
        res_value_d  = '0;
        count_d      = '0;
      end
      RES_MISS: begin
        res_status_d = ST_MISS;
        res_value_d  = '0;
      end
      default: ;
    endcase

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (dp_cmd_i.load_out) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_value_d  = res_value_q;
      out_count_d  = count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      pipe_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      pipe_vld_q  <= pipe_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q   <= pipe_idx_d;
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
  end

  assign dp_sts_o.cmd       = cmd_q;
  assign dp_sts_o.cnt_zero  = (count_q == '0);
  assign dp_sts_o.hit       = pipe_vld_q && (rdata_q == key_q);
  assign dp_sts_o.pipe_done = !pipe_vld_q && (rd_idx_q >= count_q);
  assign dp_sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_value_o = out_value_q;
  assign count_o     = out_count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_deq_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd_i.res_op == RES_DEQ) |-> (count_q != '0))
    else $error("dequeue committed on an empty queue");

endmodule

// ===== rtl/sfq_ctrl.sv =====
// Controller state machine that sequences each queue command.
module sfq_ctrl import sfq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sfq_dp_sts_t dp_sts_i,
  output sfq_dp_cmd_t dp_cmd_o
);

  sfq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (dp_sts_i.cmd) inside
          CMD_DEQ: state_d = dp_sts_i.cnt_zero ? S_RESP : S_DEQW;
          CMD_REMOVE, CMD_FIND: state_d = S_SCAN;
          default: state_d = S_RESP;
        endcase
      end
      S_DEQW: state_d = S_RESP;
      S_SCAN: begin
        if (dp_sts_i.hit) begin
          state_d = (dp_sts_i.cmd == CMD_FIND) ? S_RESP : S_SHIFT;
        end else if (dp_sts_i.pipe_done) begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (dp_sts_i.pipe_done) state_d = S_RESP;
      end
      S_RESP: begin
        if (!dp_sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o   = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        dp_cmd_o.load_item = in_valid_i;
      end
      S_EXEC: begin
        unique case (dp_sts_i.cmd) inside
          CMD_ENQ: dp_cmd_o.res_op = RES_ENQ;
          CMD_DEQ: begin
            if (dp_sts_i.cnt_zero) dp_cmd_o.res_op = RES_MISS;
            else                   dp_cmd_o.step   = 1'b1;
          end
          CMD_REMOVE, CMD_FIND: dp_cmd_o.step = 1'b1;
          CMD_CLEAR: dp_cmd_o.res_op = RES_CLEAR;
          default:   dp_cmd_o.res_op = RES_MISS;
        endcase
      end
      S_DEQW: dp_cmd_o.res_op = RES_DEQ;
      S_SCAN: begin
        if (dp_sts_i.hit) begin
          if (dp_sts_i.cmd == CMD_FIND) dp_cmd_o.res_op     = RES_FIND;
          else                          dp_cmd_o.shift_init = 1'b1;
        end else if (dp_sts_i.pipe_done) begin
          dp_cmd_o.res_op = RES_MISS;
        end else begin
          dp_cmd_o.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (dp_sts_i.pipe_done) begin
          dp_cmd_o.res_op = RES_REMOVE;
        end else begin
          dp_cmd_o.step     = 1'b1;
          dp_cmd_o.shift_wr = 1'b1;
        end
      end
      S_RESP: dp_cmd_o.load_out = !dp_sts_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/searchable_fifo_queue_top.sv =====
// Enqueue, clear and unknown commands commit their result in the execute state after acceptance;
// dequeue reads the head entry first (a miss when empty); find and remove scan one entry per cycle.
// Find stops at the first match or after the last entry; a remove then compacts the later entries one per cycle.
// One item is in flight at a time; a stalled result holds the response state until it is taken.
// Reset clears the count, head pointer and control state; the entry memory is not cleared.
// Top level of the searchable FIFO queue.
module searchable_fifo_queue_top import sfq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             cmd_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [VALUE_WIDTH-1:0] out_value_o,
  output logic [CNT_W-1:0]       count_o
);

  sfq_dp_cmd_t dp_cmd;
  sfq_dp_sts_t dp_sts;

  sfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dp_sts_i   (dp_sts),
    .dp_cmd_o   (dp_cmd)
  );

  sfq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .dp_cmd_i    (dp_cmd),
    .dp_sts_o    (dp_sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .count_o     (count_o)
  );

endmodule
